### rtl/core/rse_pkg.sv
// Shared constants, codes and controller/datapath bundles of the randomized set engine.
package rse_pkg;

	localparam int CAPACITY  = 64;
	localparam int VALUE_W   = 32;
	localparam int IDX_W     = $clog2(CAPACITY);
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int CMD_W     = 2;
	localparam int STATUS_W  = 2;
	localparam int RND_W     = 16;
	localparam int DSTEP_W   = $clog2(RND_W);

	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PICK   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_PRESENCE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

	typedef struct packed {
		logic                latch;
		logic                srch_start;
		logic                srch_run;
		logic                wr_insert;
		logic                rd_last;
		logic                wr_move;
		logic                div_start;
		logic                div_step;
		logic                rd_pick;
		logic                cap_pick;
		logic                load_rsp;
		logic                rsp_ok;
		logic [STATUS_W-1:0] rsp_status;
	} rse_cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             srch_hit;
		logic             srch_miss;
		logic             cnt_zero;
		logic             cnt_full;
		logic             div_last;
	} rse_sts_t;

endpackage

### rtl/core/rse_req_if.sv
// Request channel: command word with valid/ready handshake.
interface rse_req_if;
	logic                                valid;
	logic                                ready;
	logic [rse_pkg::CMD_W-1:0]           command;
	logic signed [rse_pkg::VALUE_W-1:0]  value;
	logic [rse_pkg::RND_W-1:0]           random_bits;

	modport source (output valid, output command, output value, output random_bits,
		input ready);
	modport sink (input valid, input command, input value, input random_bits,
		output ready);
endinterface

### rtl/core/rse_rsp_if.sv
// Response channel: result word with valid/ready handshake.
interface rse_rsp_if;
	logic                                valid;
	logic                                ready;
	logic                                success;
	logic [rse_pkg::STATUS_W-1:0]        status;
	logic signed [rse_pkg::VALUE_W-1:0]  picked_value;
	logic [rse_pkg::CNT_W-1:0]           member_count;

	modport source (output valid, output success, output status, output picked_value,
		output member_count, input ready);
	modport sink (input valid, input success, input status, input picked_value,
		input member_count, output ready);
endinterface

### rtl/core/rse_ctrl.sv
// Controller state machine of the randomized set engine.
module rse_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  rse_pkg::rse_sts_t sts,
	output rse_pkg::rse_cmd_t cmd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DISP   = 4'd1;
	localparam logic [3:0] S_SRCH   = 4'd2;
	localparam logic [3:0] S_RDLAST = 4'd3;
	localparam logic [3:0] S_MOVE   = 4'd4;
	localparam logic [3:0] S_DIV    = 4'd5;
	localparam logic [3:0] S_PKRD   = 4'd6;
	localparam logic [3:0] S_PKCAP  = 4'd7;
	localparam logic [3:0] S_FIN    = 4'd8;

	logic [3:0]                    state_q, state_d;
	logic                          res_ok_q, res_ok_d;
	logic [rse_pkg::STATUS_W-1:0]  res_st_q, res_st_d;
	logic                          out_valid_q;
	logic                          rsp_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign rsp_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d  = state_q;
		res_ok_d = res_ok_q;
		res_st_d = res_st_q;
		cmd      = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_DISP;
				end
			end
			S_DISP: begin
				res_ok_d = 1'b0;
				res_st_d = rse_pkg::ST_OK;
				case (sts.cmd)
					rse_pkg::CMD_INSERT, rse_pkg::CMD_REMOVE: begin
						cmd.srch_start = 1'b1;
						state_d        = S_SRCH;
					end
					rse_pkg::CMD_PICK: begin
						if (sts.cnt_zero) begin
							res_st_d = rse_pkg::ST_EMPTY;
							state_d  = S_FIN;
						end else begin
							cmd.div_start = 1'b1;
							state_d       = S_DIV;
						end
					end
					default: state_d = S_FIN;
				endcase
			end
			S_SRCH: begin
				cmd.srch_run = 1'b1;
				if (sts.srch_hit) begin
					if (sts.cmd == rse_pkg::CMD_INSERT) begin
						res_st_d = rse_pkg::ST_PRESENCE;
						state_d  = S_FIN;
					end else begin
						state_d = S_RDLAST;
					end
				end else if (sts.srch_miss) begin
					state_d = S_FIN;
					if (sts.cmd == rse_pkg::CMD_INSERT) begin
						if (sts.cnt_full) begin
							res_st_d = rse_pkg::ST_FULL;
						end else begin
							cmd.wr_insert = 1'b1;
							res_ok_d      = 1'b1;
						end
					end else begin
						res_st_d = rse_pkg::ST_PRESENCE;
					end
				end
			end
			S_RDLAST: begin
				cmd.rd_last = 1'b1;
				state_d     = S_MOVE;
			end
			S_MOVE: begin
				cmd.wr_move = 1'b1;
				res_ok_d    = 1'b1;
				state_d     = S_FIN;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_PKRD;
				end
			end
			S_PKRD: begin
				cmd.rd_pick = 1'b1;
				state_d     = S_PKCAP;
			end
			S_PKCAP: begin
				cmd.cap_pick = 1'b1;
				res_ok_d     = 1'b1;
				state_d      = S_FIN;
			end
			S_FIN: begin
				if (rsp_free) begin
					cmd.load_rsp = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
		cmd.rsp_ok     = res_ok_q;
		cmd.rsp_status = res_st_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_ok_q    <= 1'b0;
			res_st_q    <= rse_pkg::ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			res_ok_q <= res_ok_d;
			res_st_q <= res_st_d;
			if (cmd.load_rsp) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/core/rse_dpath.sv
// Datapath: value memory, member count, search pipeline, modulo divider, result word.
module rse_dpath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rse_pkg::rse_cmd_t                   cmd,
	output rse_pkg::rse_sts_t                   sts,
	input  logic [rse_pkg::CMD_W-1:0]           in_command,
	input  logic signed [rse_pkg::VALUE_W-1:0]  in_value,
	input  logic [rse_pkg::RND_W-1:0]           in_random_bits,
	output logic                                out_success,
	output logic [rse_pkg::STATUS_W-1:0]        out_status,
	output logic signed [rse_pkg::VALUE_W-1:0]  out_picked_value,
	output logic [rse_pkg::CNT_W-1:0]           out_member_count
);

	logic signed [rse_pkg::VALUE_W-1:0] mem [rse_pkg::CAPACITY];

	logic [rse_pkg::CMD_W-1:0]           cmd_q;
	logic signed [rse_pkg::VALUE_W-1:0]  val_q;
	logic [rse_pkg::RND_W-1:0]           dvd_q;
	logic [rse_pkg::CNT_W-1:0]           count_q;
	logic [rse_pkg::CNT_W-1:0]           iss_q;
	logic                                pend_s1;
	logic [rse_pkg::IDX_W-1:0]           idx_s1;
	logic [rse_pkg::IDX_W-1:0]           pos_q;
	logic [rse_pkg::IDX_W-1:0]           rem_q;
	logic [rse_pkg::DSTEP_W-1:0]         step_q;
	logic signed [rse_pkg::VALUE_W-1:0]  rd_data_q;
	logic signed [rse_pkg::VALUE_W-1:0]  picked_q;
	logic [rse_pkg::IDX_W-1:0]           rd_addr;
	logic [rse_pkg::CNT_W-1:0]           last_idx;
	logic [rse_pkg::CNT_W-1:0]           trial;
	logic [rse_pkg::CNT_W-1:0]           trial_sub;
	logic                                hit;
	logic                                iss_ok;

	assign last_idx  = count_q - rse_pkg::CNT_W'(1);
	assign hit       = pend_s1 && (rd_data_q == val_q);
	assign iss_ok    = iss_q < count_q;
	assign trial     = {rem_q, dvd_q[rse_pkg::RND_W-1]};
	assign trial_sub = trial - count_q;

	always_comb begin
		if (cmd.rd_last) begin
			rd_addr = last_idx[rse_pkg::IDX_W-1:0];
		end else if (cmd.rd_pick) begin
			rd_addr = rem_q;
		end else begin
			rd_addr = iss_q[rse_pkg::IDX_W-1:0];
		end
	end

	assign sts.cmd       = cmd_q;
	assign sts.srch_hit  = hit;
	assign sts.srch_miss = !pend_s1 && !iss_ok;
	assign sts.cnt_zero  = (count_q == '0);
	assign sts.cnt_full  = (count_q == rse_pkg::CNT_W'(rse_pkg::CAPACITY));
	assign sts.div_last  = (step_q == rse_pkg::DSTEP_W'(rse_pkg::RND_W - 1));

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
		if (cmd.wr_insert) begin
			mem[count_q[rse_pkg::IDX_W-1:0]] <= val_q;
		end else if (cmd.wr_move) begin
			mem[pos_q] <= rd_data_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.wr_insert) begin
			count_q <= count_q + rse_pkg::CNT_W'(1);
		end else if (cmd.wr_move) begin
			count_q <= last_idx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			cmd_q    <= in_command;
			val_q    <= in_value;
			dvd_q    <= in_random_bits;
			picked_q <= '0;
		end
		if (cmd.srch_start) begin
			iss_q   <= '0;
			pend_s1 <= 1'b0;
		end else if (cmd.srch_run) begin
			pend_s1 <= iss_ok;
			idx_s1  <= iss_q[rse_pkg::IDX_W-1:0];
			if (iss_ok) begin
				iss_q <= iss_q + rse_pkg::CNT_W'(1);
			end
			if (hit) begin
				pos_q <= idx_s1;
			end
		end
		if (cmd.div_start) begin
			rem_q  <= '0;
			step_q <= '0;
		end else if (cmd.div_step) begin
			rem_q  <= (trial >= count_q) ? trial_sub[rse_pkg::IDX_W-1:0]
				: trial[rse_pkg::IDX_W-1:0];
			dvd_q  <= {dvd_q[rse_pkg::RND_W-2:0], 1'b0};
			step_q <= step_q + rse_pkg::DSTEP_W'(1);
		end
		if (cmd.cap_pick) begin
			picked_q <= rd_data_q;
		end
		if (cmd.load_rsp) begin
			out_success      <= cmd.rsp_ok;
			out_status       <= cmd.rsp_status;
			out_picked_value <= picked_q;
			out_member_count <= count_q;
		end
	end

endmodule

### rtl/core/randomized_set_engine.sv
// Top level of the randomized set engine: controller, datapath and checks.
//
//   channel  dir  handshake      word
//   req      in   valid/ready    command, value, random_bits
//   rsp      out  valid/ready    success, status, picked_value, member_count
//
// One word at a time. Insert/remove search one entry per cycle; a remove that hits then
// moves the last entry into the freed slot. Pick takes its index from the 16-step
// bit-serial modulo of random_bits by the member count; pick on an empty set and the
// unused command go straight to the result. A held result does not
// block the next request; a new result waits in its final state until the output register frees.
// arst_n clears the member count and control; memory contents need no clearing.
module randomized_set_engine (
	input  logic       clk,
	input  logic       arst_n,
	rse_req_if.sink    req,
	rse_rsp_if.source  rsp
);

	rse_pkg::rse_cmd_t cmd;
	rse_pkg::rse_sts_t sts;

	rse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rse_dpath u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.in_command       (req.command),
		.in_value         (req.value),
		.in_random_bits   (req.random_bits),
		.out_success      (rsp.success),
		.out_status       (rsp.status),
		.out_picked_value (rsp.picked_value),
		.out_member_count (rsp.member_count)
	);

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while a word is in progress");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.member_count <= rse_pkg::CNT_W'(rse_pkg::CAPACITY))
		else $error("member count beyond capacity");

	a_success_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.success |-> rsp.status == rse_pkg::ST_OK)
		else $error("success with a failure status");

	a_one_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_rsp |-> !(rsp.valid && !rsp.ready))
		else $error("result loaded over a held word");
`endif

endmodule
